// ===== hdl/wfcg_pkg.sv =====
// ----------------------------------------------------------------------------
// wfcg_pkg
// Shared constants, control-word layout and the microprogram for the
// wait-for cycle guard.
// ----------------------------------------------------------------------------
package wfcg_pkg;

  localparam int unsigned TASKS = 32;
  localparam int unsigned IdxW  = $clog2(TASKS);
  localparam int unsigned UpcW  = 3;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [UpcW-1:0] upc_t;

  localparam logic OpCall    = 1'b0;
  localparam logic OpRelease = 1'b1;

  // Microprogram step addresses
  localparam upc_t StFetch  = 3'd0;
  localparam upc_t StDecode = 3'd1;
  localparam upc_t StWalk   = 3'd2;
  localparam upc_t StGrant  = 3'd3;
  localparam upc_t StRel    = 3'd4;
  localparam upc_t StCycle  = 3'd5;

  typedef enum logic [1:0] {
    HoldNone,
    HoldNoInput,
    HoldOutBusy
  } hold_e;

  typedef enum logic [1:0] {
    CondNever,
    CondIsRel,
    CondCurEqCaller,
    CondChainEnd
  } cond_e;

  typedef struct packed {
    hold_e hold_sel;
    cond_e cond_a;
    upc_t  addr_a;
    cond_e cond_b;
    upc_t  addr_b;
    upc_t  addr_next;
    logic  take;
    logic  advance;
    logic  wr_edge;
    logic  clr_edge;
    logic  result;
    logic  res_granted;
    logic  res_cycle;
  } uword_t;

  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    w = '{hold_sel: HoldNone, cond_a: CondNever, addr_a: StFetch,
          cond_b: CondNever, addr_b: StFetch, addr_next: StFetch,
          default: 1'b0};
    unique case (pc)
      StFetch: begin
        w.hold_sel  = HoldNoInput;
        w.take      = 1'b1;
        w.addr_next = StDecode;
      end
      StDecode: begin
        w.cond_a    = CondIsRel;
        w.addr_a    = StRel;
        w.addr_next = StWalk;
      end
      StWalk: begin
        w.cond_a    = CondCurEqCaller;
        w.addr_a    = StCycle;
        w.cond_b    = CondChainEnd;
        w.addr_b    = StGrant;
        w.advance   = 1'b1;
        w.addr_next = StWalk;
      end
      StGrant: begin
        w.hold_sel    = HoldOutBusy;
        w.wr_edge     = 1'b1;
        w.result      = 1'b1;
        w.res_granted = 1'b1;
      end
      StRel: begin
        w.hold_sel    = HoldOutBusy;
        w.clr_edge    = 1'b1;
        w.result      = 1'b1;
        w.res_granted = 1'b1;
      end
      StCycle: begin
        w.hold_sel  = HoldOutBusy;
        w.result    = 1'b1;
        w.res_cycle = 1'b1;
      end
      default: begin
        w.addr_next = StFetch;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/wfcg_if.sv =====
// ----------------------------------------------------------------------------
// wfcg_in_if / wfcg_out_if
// Valid/ready channels for requests and results of the wait-for cycle guard.
// ----------------------------------------------------------------------------
interface wfcg_in_if;
  logic            valid;
  logic            ready;
  logic            op;
  wfcg_pkg::idx_t  caller;
  wfcg_pkg::idx_t  target;

  modport source (output valid, output op, output caller, output target, input ready);
  modport sink   (input valid, input op, input caller, input target, output ready);
endinterface

interface wfcg_out_if;
  logic valid;
  logic ready;
  logic granted;
  logic cycle_found;

  modport source (output valid, output granted, output cycle_found, input ready);
  modport sink   (input valid, input granted, input cycle_found, output ready);
endinterface

// ===== hdl/wait_for_cycle_guard.sv =====
// ----------------------------------------------------------------------------
// wait_for_cycle_guard
// Wait-for table with cycle refusal, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// One transaction at a time. A release goes through the decode and release
// steps. A call goes through the decode step, then walks the chain from the
// target, reading one table entry per cycle, and ends in the grant or cycle
// step that registers the result. The next transaction is accepted in the
// cycle after the result is registered, even if the previous result has not
// yet been taken. The table holds no edges after reset; a granted call
// replaces the caller's edge, a refused one leaves the table untouched.
// ----------------------------------------------------------------------------
module wait_for_cycle_guard (
  input  logic clk_i,
  input  logic rst_ni,
  wfcg_in_if.sink    in_i,
  wfcg_out_if.source out_o
);
  import wfcg_pkg::*;

  upc_t         pc_q, pc_d;
  uword_t       uw;
  logic         op_q;
  idx_t         caller_q, target_q, cur_q, links_q;
  logic [TASKS-1:0] edge_valid_q;
  idx_t         edge_target_q [TASKS];
  logic         out_valid_q, granted_q, cycle_q;
  logic         stall, fire, hit_a, hit_b;

  function automatic logic cond_eval(input cond_e c, input logic rel, input logic eq,
                                     input logic fin);
    logic r;
    r = 1'b0;
    unique case (c)
      CondNever:       r = 1'b0;
      CondIsRel:       r = rel;
      CondCurEqCaller: r = eq;
      CondChainEnd:    r = fin;
      default:         r = 1'b0;
    endcase
    return r;
  endfunction

  logic is_rel, cur_eq, chain_end;

  assign uw        = ucode(pc_q);
  assign is_rel    = (op_q == OpRelease);
  assign cur_eq    = (cur_q == caller_q);
  assign chain_end = !edge_valid_q[cur_q] || (links_q == idx_t'(TASKS - 1));

  always_comb begin
    unique case (uw.hold_sel)
      HoldNone:    stall = 1'b0;
      HoldNoInput: stall = !in_i.valid;
      HoldOutBusy: stall = out_valid_q && !out_o.ready;
      default:     stall = 1'b0;
    endcase
  end

  assign fire  = !stall;
  assign hit_a = cond_eval(uw.cond_a, is_rel, cur_eq, chain_end);
  assign hit_b = cond_eval(uw.cond_b, is_rel, cur_eq, chain_end);

  always_comb begin
    priority if (stall) begin
      pc_d = pc_q;
    end else if (hit_a) begin
      pc_d = uw.addr_a;
    end else if (hit_b) begin
      pc_d = uw.addr_b;
    end else begin
      pc_d = uw.addr_next;
    end
  end

  assign in_i.ready = uw.take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= StFetch;
      edge_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (fire && uw.wr_edge) begin
        edge_valid_q[caller_q] <= 1'b1;
      end
      if (fire && uw.clr_edge) begin
        edge_valid_q[caller_q] <= 1'b0;
      end
      if (fire && uw.result) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (fire && uw.take) begin
      op_q     <= in_i.op;
      caller_q <= in_i.caller;
      target_q <= in_i.target;
      cur_q    <= in_i.target;
      links_q  <= '0;
    end
    if (fire && uw.advance) begin
      cur_q   <= edge_target_q[cur_q];
      links_q <= links_q + idx_t'(1);
    end
    if (fire && uw.wr_edge) begin
      edge_target_q[caller_q] <= target_q;
    end
    if (fire && uw.result) begin
      granted_q <= uw.res_granted;
      cycle_q   <= uw.res_cycle;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.granted     = granted_q;
  assign out_o.cycle_found = cycle_q;

`ifndef SYNTH
  a_take_only_in_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (pc_q == StFetch))
    else $error("transaction accepted outside fetch step");

  a_grant_sets_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == StGrant && fire) |=> edge_valid_q[$past(caller_q)])
    else $error("granted call did not record its edge");

  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(granted_q && cycle_q))
    else $error("result both granted and refused as cycle");

  a_result_registered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && uw.result) |=> (out_valid_q && pc_q == StFetch))
    else $error("result step did not present a result");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wait-for cycle guard. A queue of call and
// release transactions feeds a clocked driver; each accepted transaction is
// run through a local copy of the wait-for table to get the expected answer.
// A clocked monitor compares every result with the oldest expected answer.
// Directed cases come first, then chain-building sequences, full 32-task
// chains and random noise. Both sides stall in random bursts.
// ----------------------------------------------------------------------------
module testbench;
  import wfcg_pkg::*;

  typedef struct packed {
    logic op;
    idx_t caller;
    idx_t target;
  } call_item_t;

  typedef struct packed {
    logic granted;
    logic cycle_found;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  wfcg_in_if  in_ch ();
  wfcg_out_if out_ch ();

  wait_for_cycle_guard dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  call_item_t call_q[$];
  verdict_t   verdict_q[$];
  logic       waits [TASKS] = '{default: 1'b0};
  idx_t       wait_on [TASKS] = '{default: '0};
  int         errors = 0;
  int         queued = 0;
  bit         stim_done = 1'b0;
  int         send_gap = 0;
  int         take_gap = 0;
  call_item_t next_call;
  verdict_t   got;
  verdict_t   want;

  // Expected answer of one transaction; updates the local wait-for table.
  function automatic verdict_t judge_call(input logic op, input idx_t caller,
                                          input idx_t target);
    verdict_t v;
    idx_t     cur;
    bit       hit;
    bit       stop;
    v    = '0;
    cur  = target;
    hit  = 1'b0;
    stop = 1'b0;
    if (op == OpRelease) begin
      waits[caller]   = 1'b0;
      wait_on[caller] = '0;
      v.granted       = 1'b1;
    end else begin
      for (int n = 0; n < TASKS; n++) begin
        if (!stop) begin
          if (cur == caller) begin
            hit  = 1'b1;
            stop = 1'b1;
          end else if (!waits[cur]) begin
            stop = 1'b1;
          end else begin
            cur = wait_on[cur];
          end
        end
      end
      if (hit) begin
        v.cycle_found = 1'b1;
      end else begin
        waits[caller]   = 1'b1;
        wait_on[caller] = target;
        v.granted       = 1'b1;
      end
    end
    return v;
  endfunction

  task automatic push_call(input logic op, input int caller, input int target);
    call_item_t c;
    c.op     = op;
    c.caller = idx_t'(caller);
    c.target = idx_t'(target);
    call_q.push_back(c);
    queued++;
  endtask

  task automatic shuffle(ref int perm[TASKS]);
    int j;
    int t;
    for (int i = 0; i < TASKS; i++) perm[i] = i;
    for (int i = TASKS - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (call_q.size() != 0 || in_ch.valid || verdict_q.size() != 0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid  <= 1'b0;
      in_ch.op     <= OpCall;
      in_ch.caller <= '0;
      in_ch.target <= '0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        verdict_q.push_back(judge_call(in_ch.op, in_ch.caller, in_ch.target));
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the transaction
      end else if (send_gap != 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (call_q.size() != 0 && !(stim_done && call_q.size() < 250) &&
                   $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 16);
        in_ch.valid <= 1'b0;
      end else if (call_q.size() != 0) begin
        next_call = call_q.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.op     <= next_call.op;
        in_ch.caller <= next_call.caller;
        in_ch.target <= next_call.target;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.granted     = out_ch.granted;
        got.cycle_found = out_ch.cycle_found;
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual granted=%b cycle_found=%b",
                   $time, got.granted, got.cycle_found);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (got.granted !== want.granted) begin
            $display("%0t: granted mismatch, expected %b, actual %b",
                     $time, want.granted, got.granted);
            errors++;
          end
          if (got.cycle_found !== want.cycle_found) begin
            $display("%0t: cycle_found mismatch, expected %b, actual %b",
                     $time, want.cycle_found, got.cycle_found);
            errors++;
          end
        end
      end
      if (take_gap != 0) begin
        take_gap--;
        out_ch.ready <= 1'b0;
      end else if (!(stim_done && call_q.size() < 250) && $urandom_range(0, 7) == 0) begin
        take_gap = $urandom_range(0, 16);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of test
  initial begin
    int perm[TASKS];
    int k;
    int r;
    int n;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    push_call(OpCall, 0, 0);        // self call
    push_call(OpCall, 31, 31);      // self call
    push_call(OpRelease, 31, 31);   // nothing to clear
    push_call(OpRelease, 0, 0);
    push_call(OpCall, 0, 1);
    push_call(OpCall, 1, 2);
    push_call(OpCall, 2, 0);        // closes a loop
    push_call(OpCall, 2, 31);
    push_call(OpCall, 31, 0);       // loop through three links
    push_call(OpCall, 0, 5);        // repeated request replaces edge
    push_call(OpCall, 31, 0);
    push_call(OpCall, 5, 31);
    push_call(OpRelease, 31, 17);
    push_call(OpCall, 5, 31);
    push_call(OpCall, 1, 1);        // self call with an edge held
    push_call(OpRelease, 1, 30);
    push_call(OpCall, 2, 1);
    push_call(OpRelease, 2, 0);
    push_call(OpCall, 30, 15);
    push_call(OpCall, 15, 30);
    push_call(OpRelease, 30, 31);
    push_call(OpRelease, 15, 0);
    wait_drained();

    // random
    while (queued < 1550) begin
      r = $urandom_range(0, 99);
      shuffle(perm);
      if (r < 4) begin
        for (int i = 0; i < TASKS; i++) push_call(OpRelease, perm[i], $urandom_range(0, 31));
        for (int i = 0; i < TASKS - 1; i++) push_call(OpCall, perm[i], perm[i+1]);
        push_call(OpCall, perm[TASKS-1], perm[0]);
        push_call(OpCall, perm[TASKS-1], perm[1]);
        for (int i = 0; i < 4; i++) push_call(OpCall, $urandom_range(0, 31), $urandom_range(0, 31));
      end else if (r < 70) begin
        k = $urandom_range(0, 3) == 0 ? $urandom_range(9, 20) : $urandom_range(2, 8);
        for (int i = 0; i < k - 1; i++) push_call(OpCall, perm[i], perm[i+1]);
        push_call(OpCall, perm[k-1], perm[$urandom_range(0, k - 1)]);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
          push_call(OpCall, perm[$urandom_range(0, k - 1)], perm[$urandom_range(0, k - 1)]);
        n = $urandom_range(1, k);
        for (int i = 0; i < n; i++)
          push_call(OpRelease, perm[$urandom_range(0, k - 1)], $urandom_range(0, 31));
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          push_call(1'($urandom_range(0, 1)), $urandom_range(0, 31), $urandom_range(0, 31));
      end
    end
    stim_done = 1'b1;
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
